// File: sv/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection core.
// Request and result payload structs, lane status flags, axis codes.
`timescale 1ns / 1ps

package rbsi_pkg;

    localparam int DATA_W = 32;
    localparam int EPS_W  = 17;
    localparam int AXES   = 3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic signed [DATA_W-1:0] origin_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } t_ray_req;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] hit_t;
        logic [1:0]               normal_axis;
        logic                     normal_negative;
    } t_ray_res;

    typedef struct packed {
        logic parallel;
        logic outside;
        logic near_neg;
    } t_lane_flags;

endpackage

// File: sv/rbsi_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries the result sign alongside; no package dependencies.
`timescale 1ns / 1ps

module rbsi_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_neg
);

    // index 0 taps the inputs, index k is the register after stage k
    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [NUM_W-1:0] r_num [0:NUM_W];
    logic [NUM_W-1:0] r_quo [0:NUM_W];
    logic [DEN_W-1:0] r_den [0:NUM_W];
    logic             r_neg [0:NUM_W];

    assign r_rem[0] = '0;
    assign r_num[0] = i_num;
    assign r_quo[0] = '0;
    assign r_den[0] = i_den;
    assign r_neg[0] = i_neg;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] n_try;
        logic [DEN_W:0] n_diff;
        logic           n_ge;

        always_comb begin
            n_try  = {r_rem[k], r_num[k][NUM_W-1]};
            n_diff = n_try - {1'b0, r_den[k]};
            n_ge   = (n_try >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? n_diff[DEN_W-1:0] : n_try[DEN_W-1:0];
            r_num[k+1] <= r_num[k] << 1;
            r_quo[k+1] <= {r_quo[k][NUM_W-2:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    assign o_quo = r_quo[NUM_W];
    assign o_neg = r_neg[NUM_W];

endmodule

// File: sv/rbsi_lane.sv
// One axis lane: slab numerators, two pipelined dividers, ordering swap.
// Depends on rbsi_pkg and rbsi_div.
`timescale 1ns / 1ps

module rbsi_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic signed [rbsi_pkg::DATA_W-1:0]    i_origin,
    input  logic signed [rbsi_pkg::DATA_W-1:0]    i_dir,
    input  logic [rbsi_pkg::EPS_W-1:0]            i_eps,
    output logic signed [rbsi_pkg::DATA_W+FRAC_BITS:0] o_t_near,
    output logic signed [rbsi_pkg::DATA_W+FRAC_BITS:0] o_t_far,
    output rbsi_pkg::t_lane_flags                 o_flags
);

    localparam int DW = rbsi_pkg::DATA_W;
    localparam int NW = DW + FRAC_BITS;
    localparam int TW = NW + 1;
    localparam int BW = DW + 2;

    logic signed [BW-1:0] n_half;
    logic signed [BW-1:0] n_org;
    logic signed [BW-1:0] n_lo;
    logic signed [BW-1:0] n_hi;
    logic signed [BW-1:0] n_lo_abs;
    logic signed [BW-1:0] n_hi_abs;
    logic [DW-1:0]        n_dmag;
    logic                 n_par;
    logic                 n_out;

    always_comb begin
        n_half   = BW'(64'sd1 <<< (FRAC_BITS - 1));
        n_org    = BW'(i_origin);
        n_lo     = -n_half - n_org;
        n_hi     = n_half - n_org;
        n_lo_abs = n_lo[BW-1] ? -n_lo : n_lo;
        n_hi_abs = n_hi[BW-1] ? -n_hi : n_hi;
        n_dmag   = i_dir[DW-1] ? DW'(-i_dir) : DW'(i_dir);
        n_par    = (n_dmag < {{(DW-rbsi_pkg::EPS_W){1'b0}}, i_eps}) || (i_dir == '0);
        n_out    = (n_org < -n_half) || (n_org > n_half);
    end

    logic [NW-1:0] n_q1;
    logic [NW-1:0] n_q2;
    logic          n_neg1;
    logic          n_neg2;

    rbsi_div #(.NUM_W(NW), .DEN_W(DW)) u_div_lo (
        .i_clk (i_clk),
        .i_num ({n_lo_abs[DW-1:0], {FRAC_BITS{1'b0}}}),
        .i_den (n_dmag),
        .i_neg (n_lo[BW-1] ^ i_dir[DW-1]),
        .o_quo (n_q1),
        .o_neg (n_neg1)
    );

    rbsi_div #(.NUM_W(NW), .DEN_W(DW)) u_div_hi (
        .i_clk (i_clk),
        .i_num ({n_hi_abs[DW-1:0], {FRAC_BITS{1'b0}}}),
        .i_den (n_dmag),
        .i_neg (n_hi[BW-1] ^ i_dir[DW-1]),
        .o_quo (n_q2),
        .o_neg (n_neg2)
    );

    // hold the slab flags in step with the dividers
    logic [NW-1:0] r_par_dly;
    logic [NW-1:0] r_out_dly;

    always_ff @(posedge i_clk) begin
        r_par_dly <= {r_par_dly[NW-2:0], n_par};
        r_out_dly <= {r_out_dly[NW-2:0], n_out};
    end

    logic signed [TW-1:0] n_t1;
    logic signed [TW-1:0] n_t2;
    logic                 n_swap;

    always_comb begin
        n_t1   = n_neg1 ? -$signed({1'b0, n_q1}) : $signed({1'b0, n_q1});
        n_t2   = n_neg2 ? -$signed({1'b0, n_q2}) : $signed({1'b0, n_q2});
        n_swap = n_t1 > n_t2;
    end

    logic signed [TW-1:0]  r_t_near;
    logic signed [TW-1:0]  r_t_far;
    rbsi_pkg::t_lane_flags r_flags;

    always_ff @(posedge i_clk) begin
        r_t_near         <= n_swap ? n_t2 : n_t1;
        r_t_far          <= n_swap ? n_t1 : n_t2;
        r_flags.parallel <= r_par_dly[NW-1];
        r_flags.outside  <= r_out_dly[NW-1];
        r_flags.near_neg <= !n_swap;
    end

    assign o_t_near = r_t_near;
    assign o_t_far  = r_t_far;
    assign o_flags  = r_flags;

endmodule

// File: sv/rbsi_merge.sv
// Merge stage: largest entry, smallest exit, miss test and saturation.
// Depends on rbsi_pkg; registers the result and its strobe.
`timescale 1ns / 1ps

module rbsi_merge #(
    parameter int TW = 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [rbsi_pkg::EPS_W-1:0]   i_eps,
    input  logic signed [TW-1:0]         i_t_near [rbsi_pkg::AXES],
    input  logic signed [TW-1:0]         i_t_far  [rbsi_pkg::AXES],
    input  rbsi_pkg::t_lane_flags        i_flags  [rbsi_pkg::AXES],
    output logic                         o_valid,
    output rbsi_pkg::t_ray_res           o_res
);

    localparam int DW = rbsi_pkg::DATA_W;
    localparam logic signed [TW-1:0] T_MAX = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] T_MIN = TW'(-64'sd2147483648);

    logic signed [TW-1:0] n_near;
    logic signed [TW-1:0] n_far;
    logic signed [TW-1:0] n_eps;
    logic                 n_have;
    logic [1:0]           n_axis;
    logic                 n_neg;
    logic                 n_miss;
    rbsi_pkg::t_ray_res   n_res;

    always_comb begin
        n_near = T_MIN;
        n_far  = T_MAX;
        n_have = 1'b0;
        n_axis = rbsi_pkg::AXIS_X;
        n_neg  = 1'b0;
        n_miss = 1'b0;
        n_eps  = $signed({{(TW-rbsi_pkg::EPS_W){1'b0}}, i_eps});
        for (int a = 0; a < rbsi_pkg::AXES; a++) begin
            if (i_flags[a].parallel) begin
                if (i_flags[a].outside) n_miss = 1'b1;
            end else begin
                if (!n_have || (i_t_near[a] > n_near)) begin
                    n_near = i_t_near[a];
                    n_axis = 2'(a);
                    n_neg  = i_flags[a].near_neg;
                end
                if (!n_have || (i_t_far[a] < n_far)) n_far = i_t_far[a];
                n_have = 1'b1;
            end
        end
        // all parallel and inside: exit stays at plus infinity
        if (n_have && ((n_far < n_near) || (n_far < n_eps))) n_miss = 1'b1;

        n_res = '0;
        if (!n_miss) begin
            n_res.hit = 1'b1;
            if (!n_have || (n_near < T_MIN)) n_res.hit_t = T_MIN[DW-1:0];
            else if (n_near > T_MAX)         n_res.hit_t = T_MAX[DW-1:0];
            else                             n_res.hit_t = n_near[DW-1:0];
            n_res.normal_axis     = n_axis;
            n_res.normal_negative = n_neg;
        end
    end

    logic               r_valid;
    rbsi_pkg::t_ray_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: sv/ray_box_slab_intersect_core.sv
// Top level of the ray against unit cube slab intersection core.
// Depends on rbsi_pkg, rbsi_lane (with rbsi_div) and rbsi_merge.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive i_req and raise start; a request is taken at
//   every rising edge where start is high and busy is low. busy is tied
//   low, so one request per cycle may enter, back to back.
//   Result channel: o_res is valid for exactly one cycle while
//   o_res_valid is high. The receiver cannot stall it; capture it then.
//   Config channel: i_cfg_valid/o_cfg_ready carry epsilon (17 bits).
//   o_cfg_ready is always high; write only while no request is in flight.
//   Pipeline: from the accepting edge to the strobe, a request passes the
//   per-axis restoring dividers, one quotient bit per stage, followed by
//   the lane ordering register and the merge register.
//   Throughput: one ray per cycle; three axis lanes, two dividers each,
//   all fully pipelined.
//   Reset: synchronous, active low; clears in-flight strobes and sets
//   epsilon to 1. Requests in flight at reset are dropped.
module ray_box_slab_intersect_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rbsi_pkg::t_ray_req         i_req,
    output logic                       o_res_valid,
    output rbsi_pkg::t_ray_res         o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rbsi_pkg::EPS_W-1:0] i_cfg_data
);

    localparam int NW = rbsi_pkg::DATA_W + FRAC_BITS;
    localparam int TW = NW + 1;

    // Never push back: every stage advances each cycle.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // epsilon register
    logic [rbsi_pkg::EPS_W-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= rbsi_pkg::EPS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eps <= i_cfg_data;
        end
    end

    // request strobe travels beside the data: divider stages plus lane register
    logic [NW:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NW-1:0], start && !busy};
        end
    end

    logic signed [rbsi_pkg::DATA_W-1:0] n_org [rbsi_pkg::AXES];
    logic signed [rbsi_pkg::DATA_W-1:0] n_dir [rbsi_pkg::AXES];
    logic signed [TW-1:0]               n_t_near [rbsi_pkg::AXES];
    logic signed [TW-1:0]               n_t_far  [rbsi_pkg::AXES];
    rbsi_pkg::t_lane_flags              n_flags  [rbsi_pkg::AXES];

    assign n_org[0] = i_req.origin_x;
    assign n_org[1] = i_req.origin_y;
    assign n_org[2] = i_req.origin_z;
    assign n_dir[0] = i_req.dir_x;
    assign n_dir[1] = i_req.dir_y;
    assign n_dir[2] = i_req.dir_z;

    // one lane per axis, side by side
    for (genvar a = 0; a < rbsi_pkg::AXES; a++) begin : g_lane
        rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_origin (n_org[a]),
            .i_dir    (n_dir[a]),
            .i_eps    (r_eps),
            .o_t_near (n_t_near[a]),
            .o_t_far  (n_t_far[a]),
            .o_flags  (n_flags[a])
        );
    end

    // combine the lanes in axis order and register the result
    rbsi_merge #(.TW(TW)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[NW]),
        .i_eps    (r_eps),
        .i_t_near (n_t_near),
        .i_t_far  (n_t_far),
        .i_flags  (n_flags),
        .o_valid  (o_res_valid),
        .o_res    (o_res)
    );

endmodule

// File: verif/tb.sv
// Self-checking testbench for ray_box_slab_intersect_core: directed rays from a table,
// then random rays, checked against a typed result or an in-bench slab predictor.
// Depends on rbsi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 32 + FRAC + 2;
    localparam int N_RANDOM = 600;
    localparam longint CYCLE_LIMIT = 400000;

    // Q16.16 constants used to build rays
    localparam logic signed [31:0] Q_ONE  = 32'sd65536;
    localparam logic signed [31:0] Q_HALF = 32'sd32768;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    rbsi_pkg::t_ray_req         i_req;
    logic                       o_res_valid;
    rbsi_pkg::t_ray_res         o_res;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [rbsi_pkg::EPS_W-1:0] i_cfg_data;

    ray_box_slab_intersect_core #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor's copy of the epsilon register
    logic [rbsi_pkg::EPS_W-1:0] eps_shadow;
    rbsi_pkg::t_ray_res         hits_pending[$];
    int                         n_errors;
    longint                     n_cycles;

    // Slab test of one ray against the unit cube, 64-bit exact quotients.
    function automatic rbsi_pkg::t_ray_res slab_hit(rbsi_pkg::t_ray_req r,
                                                    logic [rbsi_pkg::EPS_W-1:0] eps_v);
        longint o, d, ad, t1, t2, tmp, tnear, tfar, eps64, one, half;
        logic [1:0] naxis;
        logic nneg, neg1, miss;
        rbsi_pkg::t_ray_res res;
        logic signed [31:0] ov[3];
        logic signed [31:0] dv[3];
        one = 64'sd1 <<< FRAC;
        half = 64'sd1 <<< (FRAC - 1);
        eps64 = longint'(eps_v);
        tnear = 64'sh8000_0000_0000_0000;
        tfar = 64'sh7FFF_FFFF_FFFF_FFFF;
        naxis = rbsi_pkg::AXIS_X;
        nneg = 1'b0;
        miss = 1'b0;
        ov[0] = r.origin_x; ov[1] = r.origin_y; ov[2] = r.origin_z;
        dv[0] = r.dir_x; dv[1] = r.dir_y; dv[2] = r.dir_z;
        for (int a = 0; a < 3; a++) begin
            o = longint'(ov[a]);
            d = longint'(dv[a]);
            ad = (d < 0) ? -d : d;
            neg1 = 1'b1;
            if (ad < eps64 || d == 0) begin
                if (o < -half || o > half) miss = 1'b1;
                continue;
            end
            t1 = ((-half - o) * one) / d;
            t2 = ((half - o) * one) / d;
            if (t1 > t2) begin
                tmp = t1; t1 = t2; t2 = tmp;
                neg1 = 1'b0;
            end
            if (t1 > tnear) begin
                tnear = t1;
                naxis = 2'(a);
                nneg = neg1;
            end
            if (t2 < tfar) tfar = t2;
        end
        if (tfar < tnear || tfar < eps64) miss = 1'b1;
        res = '0;
        if (!miss) begin
            res.hit = 1'b1;
            if (tnear > 64'sd2147483647) res.hit_t = Q_MAX;
            else if (tnear < -64'sd2147483648) res.hit_t = Q_MIN;
            else res.hit_t = tnear[31:0];
            res.normal_axis = naxis;
            res.normal_negative = nneg;
        end
        return res;
    endfunction

    // Compare a captured result with the oldest expectation.
    always @(posedge i_clk) begin
        rbsi_pkg::t_ray_res want;
        if (i_rst_n && o_res_valid) begin
            if (hits_pending.size() == 0) begin
                $error("unexpected result hit=%0b hit_t=%0d", o_res.hit, o_res.hit_t);
                n_errors++;
            end else begin
                want = hits_pending.pop_front();
                if (o_res.hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_res.hit);
                    n_errors++;
                end
                if (o_res.hit_t !== want.hit_t) begin
                    $error("hit_t: expected %0d, got %0d", want.hit_t, o_res.hit_t);
                    n_errors++;
                end
                if (o_res.normal_axis !== want.normal_axis) begin
                    $error("normal_axis: expected %0d, got %0d",
                           want.normal_axis, o_res.normal_axis);
                    n_errors++;
                end
                if (o_res.normal_negative !== want.normal_negative) begin
                    $error("normal_negative: expected %0b, got %0b",
                           want.normal_negative, o_res.normal_negative);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: fail the run if it never finishes.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one ray: wait a random gap, hold start until the core takes it.
    // start stays high after the request so the next one can follow at once.
    task automatic send_ray(rbsi_pkg::t_ray_req r, bit use_check,
                            rbsi_pkg::t_ray_res fixed);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        hits_pending.push_back(use_check ? fixed : slab_hit(r, eps_shadow));
        @(negedge i_clk);
    endtask

    // Write epsilon once the pipe is empty.
    task automatic write_eps(logic [rbsi_pkg::EPS_W-1:0] val);
        start <= 1'b0;
        while (hits_pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        eps_shadow = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 3 * 65536)) - 32'sd98304;
            2: return $signed($urandom_range(0, 65536)) - Q_HALF;
            3: return ($urandom_range(0, 1)) ? Q_HALF : -Q_HALF;
            default: return $signed($urandom_range(0, 20 * 65536)) - 32'sd655360;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_dir();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return $signed($urandom_range(0, 8)) - 32'sd4;
            2: return $signed($urandom_range(0, 2 * 65536)) - Q_ONE;
            3: return ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
            default: return $signed($urandom_range(0, 4 * 65536)) - 32'sd131072;
        endcase
    endfunction

    // Ray aimed at the box: random origin, direction toward a point inside.
    function automatic rbsi_pkg::t_ray_req aimed_ray();
        rbsi_pkg::t_ray_req r;
        r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
        r.dir_x = ($signed($urandom_range(0, 65536)) - Q_HALF) - r.origin_x;
        r.dir_y = ($signed($urandom_range(0, 65536)) - Q_HALF) - r.origin_y;
        r.dir_z = ($signed($urandom_range(0, 65536)) - Q_HALF) - r.origin_z;
        return r;
    endfunction

    // Directed table: ray, whether the result is typed in, typed result
    typedef struct {
        rbsi_pkg::t_ray_req ray;
        bit                 fixed_ok;
        rbsi_pkg::t_ray_res fixed_res;
    } t_row;

    t_row dir_rows[$];

    function automatic t_row mk(logic signed [31:0] ox, oy, oz, dx, dy, dz,
                                bit f, rbsi_pkg::t_ray_res res);
        t_row w;
        w.ray = '{ox, oy, oz, dx, dy, dz};
        w.fixed_ok = f;
        w.fixed_res = res;
        return w;
    endfunction

    initial begin
        rbsi_pkg::t_ray_res none;
        rbsi_pkg::t_ray_res inf_near;
        rbsi_pkg::t_ray_res x_entry;
        rbsi_pkg::t_ray_req r;
        int rounds;
        none = '0;
        inf_near = '{1'b1, Q_MIN, rbsi_pkg::AXIS_X, 1'b0};
        // origin at -2 on x, moving +1: enters at t = 1.5 through the minus x face
        x_entry = '{1'b1, 32'sd98304, rbsi_pkg::AXIS_X, 1'b1};
        n_errors = 0;
        n_cycles = 0;
        eps_shadow = 17'd1;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero direction, origin at center: all axes parallel and inside
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, inf_near));
        // zero direction, origin outside on x
        dir_rows.push_back(mk(Q_ONE, 0, 0, 0, 0, 0, 1, none));
        // parallel axes exactly on the faces still count as inside
        dir_rows.push_back(mk(Q_HALF, -Q_HALF, 0, 0, 0, 0, 1, inf_near));
        dir_rows.push_back(mk(-32'sd131072, 0, 0, Q_ONE, 0, 0, 1, x_entry));
        dir_rows.push_back(mk(32'sd131072, 0, 0, -Q_ONE, 0, 0, 0, none));
        dir_rows.push_back(mk(0, -32'sd131072, 0, 0, Q_ONE, 0, 0, none));
        dir_rows.push_back(mk(0, 0, 32'sd131072, 0, 0, -Q_ONE, 0, none));
        // box behind the ray
        dir_rows.push_back(mk(-32'sd131072, 0, 0, -Q_ONE, 0, 0, 1, none));
        // origin inside: negative near distance
        dir_rows.push_back(mk(0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, none));
        // diagonal tie between axes
        dir_rows.push_back(mk(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, none));
        // extremes of every field
        dir_rows.push_back(mk(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, none));
        dir_rows.push_back(mk(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, none));
        dir_rows.push_back(mk(Q_MIN, 0, 0, 32'sd1, 0, 0, 0, none));
        dir_rows.push_back(mk(Q_MIN, 0, 0, Q_MAX, 0, 0, 0, none));
        dir_rows.push_back(mk(Q_MAX, 0, 0, Q_MIN, 0, 0, 0, none));
        dir_rows.push_back(mk(-1, -1, -1, -1, -1, -1, 0, none));
        // tiny direction: entry distance saturates
        dir_rows.push_back(mk(-Q_ONE, 0, 0, 32'sd1, 0, 0, 0, none));
        // grazing exactly along a face
        dir_rows.push_back(mk(-Q_ONE, Q_HALF, 0, Q_ONE, 0, 0, 0, none));
        foreach (dir_rows[k])
            send_ray(dir_rows[k].ray, dir_rows[k].fixed_ok, dir_rows[k].fixed_res);

        // random phases under several epsilon settings, extremes included
        for (rounds = 0; rounds < 6; rounds++) begin
            case (rounds)
                0: write_eps(17'd0);
                1: write_eps(17'd65536);
                2: write_eps(17'd1);
                3: write_eps(17'h1FFFF);
                default: write_eps(17'($urandom_range(0, 65536)));
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    r = aimed_ray();
                end else begin
                    r.origin_x = rand_coord(); r.origin_y = rand_coord();
                    r.origin_z = rand_coord();
                    r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
                end
                // zero a direction now and then to hit the parallel case
                if ($urandom_range(0, 7) == 0) r.dir_y = 0;
                send_ray(r, 0, none);
            end
        end

        start <= 1'b0;
        while (hits_pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
